/* src/aavr_pkg.sv */
// ----------------------------------------------------------------------------
// Axis-angle vector rotate: shared package
// Widths, payload structs, the arctangent table and saturation helpers.
// ----------------------------------------------------------------------------
package aavr_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int TRIG_STAGES     = 16;
    localparam int CORE_W          = 16;
    localparam int Q14_ONE         = 16384;
    localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
    localparam int R_W    = 52;  // exact rotated component
    localparam int RN_W   = 32;  // normalized component
    localparam int SUM_W  = 62;  // sum of squares
    localparam int ROOT_W = 31;  // square root
    localparam int QUO_W  = 17;  // quotient bits

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] in_x;
        logic signed [COMPONENT_WIDTH-1:0] in_y;
        logic signed [COMPONENT_WIDTH-1:0] in_z;
        logic signed [COMPONENT_WIDTH-1:0] axis_x;
        logic signed [COMPONENT_WIDTH-1:0] axis_y;
        logic signed [COMPONENT_WIDTH-1:0] axis_z;
        logic signed [15:0]                angle;
    } t_req;

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] out_x;
        logic signed [COMPONENT_WIDTH-1:0] out_y;
        logic signed [COMPONENT_WIDTH-1:0] out_z;
        logic                              zero_length;
    } t_res;

    typedef struct packed {
        logic signed [CORE_W-1:0] x;
        logic signed [CORE_W-1:0] y;
        logic signed [CORE_W-1:0] z;
    } t_vec3;

    typedef struct packed {
        t_vec3 v;
        t_vec3 a;
    } t_va;

    typedef struct packed {
        logic signed [RN_W-1:0] r0;
        logic signed [RN_W-1:0] r1;
        logic signed [RN_W-1:0] r2;
        logic                   zero;
    } t_nside;

    function automatic logic [31:0] atan_val(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051D;
            2:  v = 32'h09FB385B;  3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;  9:  v = 32'h00145F2E;
            10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;  15: v = 32'h0000517C;
            16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A2F;  19: v = 32'h00000517;
            20: v = 32'h0000028B;  21: v = 32'h00000145;
            22: v = 32'h000000A2;  23: v = 32'h00000051;
            24: v = 32'h00000028;  25: v = 32'h00000014;
            26: v = 32'h0000000A;  27: v = 32'h00000005;
            28: v = 32'h00000002;  29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Sign-extend a raw component and saturate it to the 16-bit core range.
    function automatic logic signed [CORE_W-1:0] to_core(
        input logic [COMPONENT_WIDTH-1:0] raw);
        logic signed [32:0] s;
        s = 33'(signed'(raw));
        if (s < -33'sd32768) begin
            return -16'sd32768;
        end else if (s > 33'sd32767) begin
            return 16'sd32767;
        end
        return CORE_W'(s);
    endfunction

    function automatic logic signed [CORE_W-1:0] sat_q14(input logic signed [33:0] v);
        if (v > 34'sd16384) begin
            return 16'sd16384;
        end else if (v < -34'sd16384) begin
            return -16'sd16384;
        end
        return CORE_W'(v);
    endfunction

endpackage

/* src/axis_angle_vector_rotate.sv */
// ----------------------------------------------------------------------------
// Axis-angle vector rotate
// Rotates a Q1.14 vector about a unit axis by a binary angle and scales the
// result to unit length.
//
//   Channel   Ports               Direction  Handshake
//   request   start, i_req        in         taken when start is high, busy low
//   result    o_strobe, o_res     out        one cycle, no back-pressure
//
// One request may enter in every clock cycle; each result follows its request
// through the CORDIC stages, the matrix and scaling stages, and the
// square root and divider bit stages.
// busy stays low: the pipeline never stalls, since results cannot be held off.
// Synchronous reset clears only the valid bits; no request is lost in flight
// after reset is released.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate #(
    parameter int TRIG_STAGES = aavr_pkg::TRIG_STAGES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  aavr_pkg::t_req  i_req,
    output logic            o_strobe,
    output aavr_pkg::t_res  o_res
);
    localparam int DLY = TRIG_STAGES + 2;

    logic w_acc;

    aavr_pkg::t_va r_dly [DLY];
    aavr_pkg::t_va w_va;

    logic               w_cs_vld;
    logic signed [15:0] w_cos;
    logic signed [15:0] w_sin;

    logic                                w_mx_vld;
    logic signed [aavr_pkg::R_W-1:0]     w_r0, w_r1, w_r2;

    logic                                w_nm_vld;
    aavr_pkg::t_nside                    w_nm_side;
    logic [aavr_pkg::SUM_W-1:0]          w_sum;

    logic                                w_sq_vld;
    aavr_pkg::t_nside                    w_sq_side;
    logic [aavr_pkg::ROOT_W-1:0]         w_root;

    assign busy  = 1'b0;
    assign w_acc = start & ~busy;

    always_comb begin
        w_va.v.x = aavr_pkg::to_core(i_req.in_x);
        w_va.v.y = aavr_pkg::to_core(i_req.in_y);
        w_va.v.z = aavr_pkg::to_core(i_req.in_z);
        w_va.a.x = aavr_pkg::to_core(i_req.axis_x);
        w_va.a.y = aavr_pkg::to_core(i_req.axis_y);
        w_va.a.z = aavr_pkg::to_core(i_req.axis_z);
    end

    // The vector and axis wait alongside the CORDIC pipeline.
    always_ff @(posedge i_clk) begin
        r_dly[0] <= w_va;
        for (int i = 1; i < DLY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    aavr_cordic #(
        .STAGES (TRIG_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_angle (i_req.angle),
        .o_valid (w_cs_vld),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    aavr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cs_vld),
        .i_va    (r_dly[DLY-1]),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .o_valid (w_mx_vld),
        .o_r0    (w_r0),
        .o_r1    (w_r1),
        .o_r2    (w_r2)
    );

    aavr_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mx_vld),
        .i_r0    (w_r0),
        .i_r1    (w_r1),
        .i_r2    (w_r2),
        .o_valid (w_nm_vld),
        .o_side  (w_nm_side),
        .o_sum   (w_sum)
    );

    aavr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_nm_vld),
        .i_side  (w_nm_side),
        .i_sum   (w_sum),
        .o_valid (w_sq_vld),
        .o_side  (w_sq_side),
        .o_root  (w_root)
    );

    aavr_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_sq_vld),
        .i_side   (w_sq_side),
        .i_root   (w_root),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

/* src/aavr_cordic.sv */
// ----------------------------------------------------------------------------
// Axis-angle vector rotate: CORDIC cosine and sine
// One rotation step per register stage, with quadrant fold and Q1.14 rounding.
// ----------------------------------------------------------------------------
module aavr_cordic #(
    parameter int STAGES = aavr_pkg::TRIG_STAGES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [15:0]       i_angle,
    output logic              o_valid,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_sin
);
    localparam int W = 34;

    logic [STAGES:0]       r_vld;
    logic [STAGES:0]       r_flip;
    logic signed [W-1:0]   r_x [STAGES+1];
    logic signed [W-1:0]   r_y [STAGES+1];
    logic signed [W-1:0]   r_z [STAGES+1];
    logic                  r_ovld;
    logic signed [15:0]    r_cos;
    logic signed [15:0]    r_sin;

    logic [31:0]         w_p;
    logic                w_flip;
    logic [31:0]         w_pf;
    logic signed [W-1:0] w_xf;
    logic signed [W-1:0] w_yf;

    // Angles in the left half plane are folded by pi and the result negated.
    assign w_p    = {i_angle, 16'h0000};
    assign w_flip = w_p[31] ^ w_p[30];
    assign w_pf   = {w_p[31] ^ w_flip, w_p[30:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flip[0] <= w_flip;
        r_x[0]    <= W'(signed'({1'b0, aavr_pkg::CORDIC_GAIN}));
        r_y[0]    <= '0;
        r_z[0]    <= W'(signed'(w_pf));
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_step
        localparam logic signed [W-1:0] ATAN = W'(signed'({1'b0, aavr_pkg::atan_val(g)}));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_flip[g+1] <= r_flip[g];
            if (r_z[g] >= 0) begin
                r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] - ATAN;
            end else begin
                r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] + ATAN;
            end
        end
    end

    assign w_xf = r_flip[STAGES] ? -r_x[STAGES] : r_x[STAGES];
    assign w_yf = r_flip[STAGES] ? -r_y[STAGES] : r_y[STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos <= aavr_pkg::sat_q14((w_xf + 34'sd32768) >>> 16);
        r_sin <= aavr_pkg::sat_q14((w_yf + 34'sd32768) >>> 16);
    end

    assign o_valid = r_ovld;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

/* src/aavr_matrix.sv */
// ----------------------------------------------------------------------------
// Axis-angle vector rotate: rotation matrix and product
// Builds the Rodrigues matrix in Q28 and multiplies the vector by it exactly.
// ----------------------------------------------------------------------------
module aavr_matrix (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  aavr_pkg::t_va                     i_va,
    input  logic signed [15:0]                i_cos,
    input  logic signed [15:0]                i_sin,
    output logic                              o_valid,
    output logic signed [aavr_pkg::R_W-1:0]   o_r0,
    output logic signed [aavr_pkg::R_W-1:0]   o_r1,
    output logic signed [aavr_pkg::R_W-1:0]   o_r2
);
    localparam int R_W = aavr_pkg::R_W;

    logic [4:0] r_vld;

    // Stage 1: axis products and sine terms.
    logic signed [31:0] r1_xx, r1_yy, r1_zz, r1_xy, r1_xz, r1_yz;
    logic signed [31:0] r1_xs, r1_ys, r1_zs;
    logic signed [16:0] r1_omc;
    logic signed [15:0] r1_c;
    aavr_pkg::t_vec3    r1_v;
    // Stage 2: scaling by one minus cosine.
    logic signed [47:0] r2_xx, r2_yy, r2_zz, r2_xy, r2_xz, r2_yz;
    logic signed [31:0] r2_xs, r2_ys, r2_zs;
    logic signed [15:0] r2_c;
    aavr_pkg::t_vec3    r2_v;
    // Stage 3: matrix entries in Q28.
    logic signed [34:0] r3_m [9];
    aavr_pkg::t_vec3    r3_v;
    // Stage 4: entry times component.
    logic signed [50:0] r4_p [9];
    // Stage 5: row sums.
    logic signed [R_W-1:0] r5_r [3];

    logic signed [47:0] w_cc, w_sx, w_sy, w_sz;
    logic signed [47:0] w_e [9];
    logic signed [15:0] w_vc [3];

    function automatic logic signed [34:0] rnd14(input logic signed [47:0] e);
        logic signed [47:0] t;
        t = (e + 48'sd8192) >>> 14;
        return 35'(t);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_xx  <= i_va.a.x * i_va.a.x;
        r1_yy  <= i_va.a.y * i_va.a.y;
        r1_zz  <= i_va.a.z * i_va.a.z;
        r1_xy  <= i_va.a.x * i_va.a.y;
        r1_xz  <= i_va.a.x * i_va.a.z;
        r1_yz  <= i_va.a.y * i_va.a.z;
        r1_xs  <= i_va.a.x * i_sin;
        r1_ys  <= i_va.a.y * i_sin;
        r1_zs  <= i_va.a.z * i_sin;
        r1_omc <= 17'sd16384 - 17'(i_cos);
        r1_c   <= i_cos;
        r1_v   <= i_va.v;
    end

    always_ff @(posedge i_clk) begin
        r2_xx <= 48'(r1_xx * r1_omc);
        r2_yy <= 48'(r1_yy * r1_omc);
        r2_zz <= 48'(r1_zz * r1_omc);
        r2_xy <= 48'(r1_xy * r1_omc);
        r2_xz <= 48'(r1_xz * r1_omc);
        r2_yz <= 48'(r1_yz * r1_omc);
        r2_xs <= r1_xs;
        r2_ys <= r1_ys;
        r2_zs <= r1_zs;
        r2_c  <= r1_c;
        r2_v  <= r1_v;
    end

    always_comb begin
        w_cc = 48'(r2_c) <<< 28;
        w_sx = 48'(r2_xs) <<< 14;
        w_sy = 48'(r2_ys) <<< 14;
        w_sz = 48'(r2_zs) <<< 14;
        w_e[0] = r2_xx + w_cc;
        w_e[1] = r2_xy - w_sz;
        w_e[2] = r2_xz + w_sy;
        w_e[3] = r2_xy + w_sz;
        w_e[4] = r2_yy + w_cc;
        w_e[5] = r2_yz - w_sx;
        w_e[6] = r2_xz - w_sy;
        w_e[7] = r2_yz + w_sx;
        w_e[8] = r2_zz + w_cc;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r3_m[k] <= rnd14(w_e[k]);
        end
        r3_v <= r2_v;
    end

    assign w_vc[0] = r3_v.x;
    assign w_vc[1] = r3_v.y;
    assign w_vc[2] = r3_v.z;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r4_p[k] <= 51'(r3_m[k] * w_vc[k % 3]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r5_r[i] <= R_W'(r4_p[3*i]) + R_W'(r4_p[3*i+1]) + R_W'(r4_p[3*i+2]);
        end
    end

    assign o_valid = r_vld[4];
    assign o_r0    = r5_r[0];
    assign o_r1    = r5_r[1];
    assign o_r2    = r5_r[2];

endmodule

/* src/aavr_norm.sv */
// ----------------------------------------------------------------------------
// Axis-angle vector rotate: block scaling and sum of squares
// Finds the largest magnitude, scales all three components by a power of two
// so that it lands in [2^29, 2^30), and squares and sums them.
// ----------------------------------------------------------------------------
module aavr_norm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [aavr_pkg::R_W-1:0]     i_r0,
    input  logic signed [aavr_pkg::R_W-1:0]     i_r1,
    input  logic signed [aavr_pkg::R_W-1:0]     i_r2,
    output logic                                o_valid,
    output aavr_pkg::t_nside                    o_side,
    output logic [aavr_pkg::SUM_W-1:0]          o_sum
);
    localparam int R_W   = aavr_pkg::R_W;
    localparam int RN_W  = aavr_pkg::RN_W;
    localparam int SUM_W = aavr_pkg::SUM_W;
    localparam int PW    = $clog2(R_W);

    logic [5:0] r_vld;

    logic signed [R_W-1:0] r1_r [3];
    logic [R_W-1:0]        r1_m [3];
    logic signed [R_W-1:0] r2_r [3];
    logic [R_W-1:0]        r2_max;
    logic signed [R_W-1:0] r3_r [3];
    logic [PW-1:0]         r3_pos;
    logic                  r3_zero;
    logic signed [RN_W-1:0] r4_r [3];
    logic                   r4_zero;
    logic signed [RN_W-1:0] r5_r [3];
    logic [SUM_W-1:0]       r5_sq [3];
    logic                   r5_zero;
    aavr_pkg::t_nside       r6_side;
    logic [SUM_W-1:0]       r6_sum;

    logic [R_W-1:0]   w_max;
    logic [PW-1:0]    w_pos;
    logic [PW-1:0]    w_sh;
    logic signed [RN_W-1:0] w_rn [3];
    logic [RN_W-1:0]  w_mag [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_r[0] <= i_r0;
        r1_r[1] <= i_r1;
        r1_r[2] <= i_r2;
        r1_m[0] <= i_r0[R_W-1] ? R_W'(-i_r0) : R_W'(i_r0);
        r1_m[1] <= i_r1[R_W-1] ? R_W'(-i_r1) : R_W'(i_r1);
        r1_m[2] <= i_r2[R_W-1] ? R_W'(-i_r2) : R_W'(i_r2);
    end

    always_comb begin
        w_max = r1_m[0];
        if (r1_m[1] > w_max) begin
            w_max = r1_m[1];
        end
        if (r1_m[2] > w_max) begin
            w_max = r1_m[2];
        end
    end

    always_ff @(posedge i_clk) begin
        r2_r   <= r1_r;
        r2_max <= w_max;
    end

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < R_W; i++) begin
            if (r2_max[i]) begin
                w_pos = PW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r3_r    <= r2_r;
        r3_pos  <= w_pos;
        r3_zero <= (r2_max == '0);
    end

    // Floor shift going down, exact shift going up.
    always_comb begin
        if (r3_pos >= PW'(30)) begin
            w_sh = r3_pos - PW'(29);
            for (int i = 0; i < 3; i++) begin
                w_rn[i] = RN_W'(r3_r[i] >>> w_sh);
            end
        end else begin
            w_sh = PW'(29) - r3_pos;
            for (int i = 0; i < 3; i++) begin
                w_rn[i] = RN_W'(r3_r[i] <<< w_sh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r4_r    <= w_rn;
        r4_zero <= r3_zero;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r4_r[i][RN_W-1] ? RN_W'(-r4_r[i]) : RN_W'(r4_r[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r5_r    <= r4_r;
        r5_zero <= r4_zero;
        for (int i = 0; i < 3; i++) begin
            r5_sq[i] <= SUM_W'(w_mag[i][RN_W-2:0] * w_mag[i][RN_W-2:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r6_side.r0   <= r5_r[0];
        r6_side.r1   <= r5_r[1];
        r6_side.r2   <= r5_r[2];
        r6_side.zero <= r5_zero;
        r6_sum       <= r5_sq[0] + r5_sq[1] + r5_sq[2];
    end

    assign o_valid = r_vld[5];
    assign o_side  = r6_side;
    assign o_sum   = r6_sum;

endmodule

/* src/aavr_isqrt.sv */
// ----------------------------------------------------------------------------
// Axis-angle vector rotate: pipelined integer square root
// Digit-by-digit floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module aavr_isqrt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  aavr_pkg::t_nside                   i_side,
    input  logic [aavr_pkg::SUM_W-1:0]         i_sum,
    output logic                               o_valid,
    output aavr_pkg::t_nside                   o_side,
    output logic [aavr_pkg::ROOT_W-1:0]        o_root
);
    localparam int STEPS = 32;

    logic [STEPS:0]     r_vld;
    logic [63:0]        r_v    [STEPS+1];
    logic [63:0]        r_res  [STEPS+1];
    aavr_pkg::t_nside   r_side [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v[0]    <= 64'(i_sum);
        r_res[0]  <= '0;
        r_side[0] <= i_side;
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam logic [63:0] BIT = 64'(1) << (62 - 2*g);
        logic [63:0] w_trial;

        assign w_trial = r_res[g] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[g+1] <= r_side[g];
            if (r_v[g] >= w_trial) begin
                r_v[g+1]   <= r_v[g] - w_trial;
                r_res[g+1] <= (r_res[g] >> 1) + BIT;
            end else begin
                r_v[g+1]   <= r_v[g];
                r_res[g+1] <= r_res[g] >> 1;
            end
        end
    end

    assign o_valid = r_vld[STEPS];
    assign o_side  = r_side[STEPS];
    assign o_root  = r_res[STEPS][aavr_pkg::ROOT_W-1:0];

endmodule

/* src/aavr_div.sv */
// ----------------------------------------------------------------------------
// Axis-angle vector rotate: normalizing divider
// Three restoring dividers in lockstep, one quotient bit per register stage,
// rounding half away from zero, then saturation and sign.
// ----------------------------------------------------------------------------
module aavr_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  aavr_pkg::t_nside                i_side,
    input  logic [aavr_pkg::ROOT_W-1:0]     i_root,
    output logic                            o_strobe,
    output aavr_pkg::t_res                  o_res
);
    localparam int QW   = aavr_pkg::QUO_W;
    localparam int RN_W = aavr_pkg::RN_W;
    localparam int CW   = aavr_pkg::COMPONENT_WIDTH;
    localparam int NW   = 48;
    localparam int DW   = 32;
    localparam int TW   = NW + 2;

    logic [QW:0]           r_vld;
    logic [2:0][NW-1:0]    r_rem  [QW+1];
    logic [2:0][QW-1:0]    r_q    [QW+1];
    logic [2:0]            r_neg  [QW+1];
    logic [DW-1:0]         r_den  [QW+1];
    logic                  r_zero [QW+1];
    logic                  r_ovld;
    aavr_pkg::t_res        r_res;

    logic signed [RN_W-1:0] w_r  [3];
    logic [RN_W-1:0]        w_mag [3];
    logic signed [CW-1:0]   w_out [3];

    assign w_r[0] = i_side.r0;
    assign w_r[1] = i_side.r1;
    assign w_r[2] = i_side.r2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = w_r[i][RN_W-1] ? RN_W'(-w_r[i]) : RN_W'(w_r[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_rem[0][i] <= (NW'(w_mag[i]) << 15) + NW'(i_root);
            r_q[0][i]   <= '0;
            r_neg[0][i] <= w_r[i][RN_W-1];
        end
        r_den[0]  <= {i_root, 1'b0};
        r_zero[0] <= i_side.zero;
    end

    for (genvar g = 0; g < QW; g++) begin : g_step
        localparam int B = QW - 1 - g;
        logic [TW-1:0] w_trial;

        assign w_trial = TW'(r_den[g]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[g+1]  <= r_den[g];
            r_zero[g+1] <= r_zero[g];
            r_neg[g+1]  <= r_neg[g];
            for (int i = 0; i < 3; i++) begin
                if (TW'(r_rem[g][i]) >= w_trial) begin
                    r_rem[g+1][i] <= NW'(TW'(r_rem[g][i]) - w_trial);
                    r_q[g+1][i]   <= {r_q[g][i][QW-2:0], 1'b1};
                end else begin
                    r_rem[g+1][i] <= r_rem[g][i];
                    r_q[g+1][i]   <= {r_q[g][i][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        logic signed [QW:0] q;
        for (int i = 0; i < 3; i++) begin
            if (r_q[QW][i] > QW'(aavr_pkg::Q14_ONE)) begin
                q = (QW+1)'(aavr_pkg::Q14_ONE);
            end else begin
                q = signed'({1'b0, r_q[QW][i]});
            end
            if (r_zero[QW]) begin
                w_out[i] = '0;
            end else if (r_neg[QW][i]) begin
                w_out[i] = CW'(-q);
            end else begin
                w_out[i] = CW'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.out_x       <= w_out[0];
        r_res.out_y       <= w_out[1];
        r_res.out_z       <= w_out[2];
        r_res.zero_length <= r_zero[QW];
    end

    assign o_strobe = r_ovld;
    assign o_res    = r_res;

endmodule
